### design/sere_pkg.sv
// shared types and constants for the scatter-elements reduce block
package sere_pkg;

    localparam int DATA_W  = 32;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int SEL_W   = 2;

    localparam int PLANE_W = 2 * DIM_W;
    localparam int ROW_W   = COORD_W + DIM_W;
    localparam int OFF_W   = COORD_W + PLANE_W;
    localparam int PART_W  = ROW_W + 1;
    localparam int FLAT_W  = OFF_W + 1;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [SEL_W-1:0] t_sel;

    localparam t_sel ACT_LOAD    = 2'd0;
    localparam t_sel ACT_SCATTER = 2'd1;
    localparam t_sel ACT_READ    = 2'd2;

    localparam t_sel MODE_OVERWRITE = 2'd0;
    localparam t_sel MODE_ADD       = 2'd1;
    localparam t_sel MODE_MUL       = 2'd2;

    localparam t_sel AXIS_OUTER  = 2'd0;
    localparam t_sel AXIS_MIDDLE = 2'd1;
    localparam t_sel AXIS_INNER  = 2'd2;

    localparam t_sel REG_AXIS       = 2'd0;
    localparam t_sel REG_MODE       = 2'd1;
    localparam t_sel REG_DIM_MIDDLE = 2'd2;
    localparam t_sel REG_DIM_INNER  = 2'd3;

endpackage

### design/scatter_elements_reduce_3d.sv
// top level of the scatter-elements reduce block over a flat 3-d tensor store
//
// input queue: an item is taken at a clock edge with i_push high and o_full low.
// action load writes one store entry, read returns one, scatter forms the flat
// address outer*dim_middle*dim_inner + middle*dim_inner + inner, with the
// configured axis coordinate replaced by the index, and overwrites, adds to or
// multiplies the entry. every item gives exactly one result beat.
// result queue: the oldest result is on o_read_data/o_range_error while o_empty
// is low and leaves at an edge with i_pop high; an out-of-range address gives
// range_error 1, data 0 and no store update.
// flow: the back end takes a new item only after the read-modify-write of the
// last one on the single store port; the address pipeline and two queues let
// input keep coming while results wait, until the queues fill and o_full rises.
// configuration: apb registers at byte offsets 0 axis, 4 mode, 8 dim_middle,
// 12 dim_inner; write only while no item is in flight.
// reset: synchronous, clears queues, pipeline and registers (axis 0, mode 0,
// dims 1); the store holds no defined data until written.
module scatter_elements_reduce_3d #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sere_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sere_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sere_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [1:0]                          i_action,
    input  logic [11:0]                         i_flat_address,
    input  logic signed [31:0]                  i_data_value,
    input  logic [11:0]                         i_scatter_index,
    input  logic [11:0]                         i_pos_outer,
    input  logic [11:0]                         i_pos_middle,
    input  logic [11:0]                         i_pos_inner,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [31:0]                  o_read_data,
    output logic                                o_range_error
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int MID_W = sere_pkg::SEL_W + AW + sere_pkg::DATA_W + 1;
    localparam int OUT_W = sere_pkg::DATA_W + 1;
    localparam int MCW   = $clog2(sere_pkg::MID_DEPTH + 1);
    localparam int OCW   = $clog2(sere_pkg::OUT_DEPTH + 1);

    sere_pkg::t_sel              r_axis;
    sere_pkg::t_sel              r_mode;
    logic [sere_pkg::DIM_W-1:0]  r_dim_middle;
    logic [sere_pkg::DIM_W-1:0]  r_dim_inner;
    sere_pkg::t_sel              reg_idx;
    logic                        cfg_wr;

    logic                        accept;
    logic                        f_push;
    sere_pkg::t_sel              f_action;
    logic [AW-1:0]               f_addr;
    logic [sere_pkg::DATA_W-1:0] f_data;
    logic                        f_err;
    logic [1:0]                  f_fill;

    logic [MID_W-1:0]            mid_head;
    logic                        mid_empty;
    logic [MCW-1:0]              mid_count;
    logic [MCW:0]                in_flight;

    sere_pkg::t_sel              b_action;
    logic [AW-1:0]               b_addr;
    logic [sere_pkg::DATA_W-1:0] b_data;
    logic                        b_err;
    logic                        b_pop;
    logic                        b_push;
    logic [sere_pkg::DATA_W-1:0] b_result;
    logic                        b_res_err;

    logic [OUT_W-1:0]            out_head;
    logic [OCW-1:0]              out_count;
    logic                        out_pop;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis       <= sere_pkg::AXIS_OUTER;
            r_mode       <= sere_pkg::MODE_OVERWRITE;
            r_dim_middle <= sere_pkg::DIM_W'(1);
            r_dim_inner  <= sere_pkg::DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sere_pkg::REG_AXIS:       r_axis       <= pwdata[sere_pkg::SEL_W-1:0];
                sere_pkg::REG_MODE:       r_mode       <= pwdata[sere_pkg::SEL_W-1:0];
                sere_pkg::REG_DIM_MIDDLE: r_dim_middle <= pwdata[sere_pkg::DIM_W-1:0];
                sere_pkg::REG_DIM_INNER:  r_dim_inner  <= pwdata[sere_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sere_pkg::REG_AXIS:       prdata = sere_pkg::CFG_DATA_W'(r_axis);
            sere_pkg::REG_MODE:       prdata = sere_pkg::CFG_DATA_W'(r_mode);
            sere_pkg::REG_DIM_MIDDLE: prdata = sere_pkg::CFG_DATA_W'(r_dim_middle);
            sere_pkg::REG_DIM_INNER:  prdata = sere_pkg::CFG_DATA_W'(r_dim_inner);
            default:                  prdata = '0;
        endcase
    end

    // every item in the front holds a slot in the middle queue
    assign in_flight = (MCW + 1)'(f_fill) + (MCW + 1)'(mid_count);
    assign o_full    = (in_flight >= (MCW + 1)'(sere_pkg::MID_DEPTH));
    assign accept    = i_push && !o_full;

    sere_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_action        (i_action),
        .i_flat_address  (i_flat_address),
        .i_data_value    (i_data_value),
        .i_scatter_index (i_scatter_index),
        .i_pos_outer     (i_pos_outer),
        .i_pos_middle    (i_pos_middle),
        .i_pos_inner     (i_pos_inner),
        .i_axis          (r_axis),
        .i_dim_middle    (r_dim_middle),
        .i_dim_inner     (r_dim_inner),
        .o_push          (f_push),
        .o_action        (f_action),
        .o_addr          (f_addr),
        .o_data          (f_data),
        .o_err           (f_err),
        .o_fill          (f_fill)
    );

    sere_fifo #(
        .WIDTH (MID_W),
        .DEPTH (sere_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_action, f_addr, f_data, f_err}),
        .i_pop   (b_pop),
        .o_data  (mid_head),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign {b_action, b_addr, b_data, b_err} = mid_head;

    sere_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_empty    (mid_empty),
        .i_action   (b_action),
        .i_addr     (b_addr),
        .i_data     (b_data),
        .i_err      (b_err),
        .i_out_room (out_count < OCW'(sere_pkg::OUT_DEPTH)),
        .o_pop      (b_pop),
        .o_push     (b_push),
        .o_result   (b_result),
        .o_err      (b_res_err)
    );

    assign out_pop = i_pop && !o_empty;

    sere_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (sere_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  ({b_result, b_res_err}),
        .i_pop   (out_pop),
        .o_data  (out_head),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_read_data   = out_head[OUT_W-1:1];
    assign o_range_error = out_head[0];

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= (MCW + 1)'(sere_pkg::MID_DEPTH))
        else $error("middle queue slots overbooked");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> (out_count < OCW'(sere_pkg::OUT_DEPTH)) || out_pop)
        else $error("result beat pushed into full queue");

    a_pop_then_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |=> b_push && !b_pop)
        else $error("back end did not finish item in two cycles");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_push && b_res_err) |-> (b_result == '0))
        else $error("range error beat carries data");
`endif

endmodule

### design/sere_fifo.sv
// small register queue used between the front, the back and the result port
module sere_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

### design/sere_front.sv
// front pipeline: coordinate select, flat address multiplies and range check
module sere_front #(
    parameter int STORE_DEPTH = 4096,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  sere_pkg::t_sel                 i_action,
    input  logic [sere_pkg::COORD_W-1:0]   i_flat_address,
    input  logic [sere_pkg::DATA_W-1:0]    i_data_value,
    input  logic [sere_pkg::COORD_W-1:0]   i_scatter_index,
    input  logic [sere_pkg::COORD_W-1:0]   i_pos_outer,
    input  logic [sere_pkg::COORD_W-1:0]   i_pos_middle,
    input  logic [sere_pkg::COORD_W-1:0]   i_pos_inner,
    input  sere_pkg::t_sel                 i_axis,
    input  logic [sere_pkg::DIM_W-1:0]     i_dim_middle,
    input  logic [sere_pkg::DIM_W-1:0]     i_dim_inner,
    output logic                           o_push,
    output sere_pkg::t_sel                 o_action,
    output logic [AW-1:0]                  o_addr,
    output logic [sere_pkg::DATA_W-1:0]    o_data,
    output logic                           o_err,
    output logic [1:0]                     o_fill
);

    logic [sere_pkg::COORD_W-1:0] n_o, n_m, n_i;

    logic                          r_v1;
    sere_pkg::t_sel                r_act1;
    logic [sere_pkg::DATA_W-1:0]   r_data1;
    logic [sere_pkg::COORD_W-1:0]  r_o1, r_m1, r_i1;

    logic                          r_v2;
    sere_pkg::t_sel                r_act2;
    logic [sere_pkg::DATA_W-1:0]   r_data2;
    logic [sere_pkg::COORD_W-1:0]  r_o2, r_i2;
    logic [sere_pkg::PLANE_W-1:0]  r_plane2;
    logic [sere_pkg::ROW_W-1:0]    r_row2;

    logic                          r_v3;
    sere_pkg::t_sel                r_act3;
    logic [sere_pkg::DATA_W-1:0]   r_data3;
    logic [sere_pkg::OFF_W-1:0]    r_off3;
    logic [sere_pkg::PART_W-1:0]   r_part3;

    logic [sere_pkg::FLAT_W-1:0]   flat;

    // load and read go through the same path as coordinates (0, 0, address)
    always_comb begin
        n_o = '0;
        n_m = '0;
        n_i = i_flat_address;
        if (i_action == sere_pkg::ACT_SCATTER) begin
            n_o = i_pos_outer;
            n_m = i_pos_middle;
            n_i = i_pos_inner;
            priority if (i_axis == sere_pkg::AXIS_OUTER) begin
                n_o = i_scatter_index;
            end else if (i_axis == sere_pkg::AXIS_MIDDLE) begin
                n_m = i_scatter_index;
            end else begin
                n_i = i_scatter_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act1  <= i_action;
        r_data1 <= i_data_value;
        r_o1    <= n_o;
        r_m1    <= n_m;
        r_i1    <= n_i;

        r_act2   <= r_act1;
        r_data2  <= r_data1;
        r_o2     <= r_o1;
        r_i2     <= r_i1;
        r_plane2 <= sere_pkg::PLANE_W'(i_dim_middle) * sere_pkg::PLANE_W'(i_dim_inner);
        r_row2   <= sere_pkg::ROW_W'(r_m1) * sere_pkg::ROW_W'(i_dim_inner);

        r_act3  <= r_act2;
        r_data3 <= r_data2;
        r_off3  <= sere_pkg::OFF_W'(r_o2) * sere_pkg::OFF_W'(r_plane2);
        r_part3 <= sere_pkg::PART_W'(r_row2) + sere_pkg::PART_W'(r_i2);
    end

    assign flat     = sere_pkg::FLAT_W'(r_off3) + sere_pkg::FLAT_W'(r_part3);
    assign o_err    = (flat >= sere_pkg::FLAT_W'(STORE_DEPTH));
    assign o_addr   = flat[AW-1:0];
    assign o_push   = r_v3;
    assign o_action = r_act3;
    assign o_data   = r_data3;
    assign o_fill   = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule

### design/sere_back.sv
// back end: tensor store with read-modify-write sequencer
module sere_back #(
    parameter int STORE_DEPTH = 4096,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sere_pkg::t_sel               i_mode,
    input  logic                         i_empty,
    input  sere_pkg::t_sel               i_action,
    input  logic [AW-1:0]                i_addr,
    input  logic [sere_pkg::DATA_W-1:0]  i_data,
    input  logic                         i_err,
    input  logic                         i_out_room,
    output logic                         o_pop,
    output logic                         o_push,
    output logic [sere_pkg::DATA_W-1:0]  o_result,
    output logic                         o_err
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic [sere_pkg::DATA_W-1:0] r_store [STORE_DEPTH];

    logic                        r_state, n_state;
    sere_pkg::t_sel              r_action;
    logic [AW-1:0]               r_addr;
    logic [sere_pkg::DATA_W-1:0] r_data;
    logic                        r_err;
    logic [sere_pkg::DATA_W-1:0] r_old;
    logic [sere_pkg::DATA_W-1:0] value;
    logic [sere_pkg::DATA_W-1:0] reduced;
    logic                        wr_en;

    assign o_pop = (r_state == ST_IDLE) && !i_empty && i_out_room;

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = o_pop ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= i_action;
            r_addr   <= i_addr;
            r_data   <= i_data;
            r_err    <= i_err;
        end
    end

    always_comb begin
        unique case (i_mode)
            sere_pkg::MODE_OVERWRITE: reduced = r_data;
            sere_pkg::MODE_ADD:       reduced = r_old + r_data;
            default:                  reduced = r_old * r_data;
        endcase
    end

    always_comb begin
        value = r_old;
        if (r_action == sere_pkg::ACT_LOAD) begin
            value = r_data;
        end else if (r_action == sere_pkg::ACT_SCATTER) begin
            value = reduced;
        end
    end

    assign wr_en = (r_state == ST_EXEC) && !r_err &&
                   ((r_action == sere_pkg::ACT_LOAD) || (r_action == sere_pkg::ACT_SCATTER));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_addr] <= value;
        end
        if (o_pop && !i_err) begin
            r_old <= r_store[i_addr];
        end
    end

    assign o_push   = (r_state == ST_EXEC);
    assign o_result = r_err ? '0 : value;
    assign o_err    = r_err;

endmodule

### dv/scatter_elements_reduce_3d_check.sv
// scoreboard for the scatter-elements reduce block: tracks registers and store, checks results
package sere_test_pkg;
    import sere_pkg::*;

    // selector values the block folds onto its neighbors
    localparam t_sel ACT_READ_ALT     = 2'd3;
    localparam t_sel AXIS_ALIAS_INNER = 2'd3;
    localparam t_sel MODE_ALIAS_MUL   = 2'd3;

    function automatic logic [63:0] tensor_offset(
        t_sel axis, logic [DIM_W-1:0] dm, logic [DIM_W-1:0] di,
        logic [COORD_W-1:0] si, logic [COORD_W-1:0] po,
        logic [COORD_W-1:0] pm, logic [COORD_W-1:0] pi
    );
        logic [63:0] o;
        logic [63:0] m;
        logic [63:0] n;
        o = po;
        m = pm;
        n = pi;
        case (axis)
            AXIS_OUTER:  o = si;
            AXIS_MIDDLE: m = si;
            default:     n = si;
        endcase
        return o * dm * di + m * di + n;
    endfunction
endpackage

module scatter_elements_reduce_3d_check #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [sere_pkg::CFG_ADDR_W-1:0]  i_paddr,
    input  logic [sere_pkg::CFG_DATA_W-1:0]  i_pwdata,
    input  logic [sere_pkg::CFG_DATA_W-1:0]  i_prdata,
    input  logic                             i_pready,
    input  logic                             i_push,
    input  logic                             i_full,
    input  logic [1:0]                       i_action,
    input  logic [11:0]                      i_flat_address,
    input  logic [31:0]                      i_data_value,
    input  logic [11:0]                      i_scatter_index,
    input  logic [11:0]                      i_pos_outer,
    input  logic [11:0]                      i_pos_middle,
    input  logic [11:0]                      i_pos_inner,
    input  logic                             i_empty,
    input  logic                             i_pop,
    input  logic [31:0]                      i_read_data,
    input  logic                             i_range_error,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sere_pkg::*;
    import sere_test_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              range_error;
    } scatter_result_t;

    scatter_result_t   expected_results[$];
    logic [DATA_W-1:0] tensor_store [STORE_DEPTH];
    t_sel              axis_reg;
    t_sel              mode_reg;
    logic [DIM_W-1:0]  dim_middle_reg;
    logic [DIM_W-1:0]  dim_inner_reg;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch at %0t: %s expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    task automatic predict_beat(
        t_sel act, logic [11:0] fa, logic [31:0] dval,
        logic [11:0] si, logic [11:0] po, logic [11:0] pm, logic [11:0] pi
    );
        logic [63:0]       addr;
        logic [DATA_W-1:0] prev;
        scatter_result_t   res;
        if (act == ACT_SCATTER) begin
            addr = tensor_offset(axis_reg, dim_middle_reg, dim_inner_reg, si, po, pm, pi);
        end else begin
            addr = fa;
        end
        res = '0;
        if (addr >= STORE_DEPTH) begin
            res.range_error = 1'b1;
        end else if (act == ACT_LOAD) begin
            tensor_store[addr] = dval;
            res.data = dval;
        end else if (act == ACT_SCATTER) begin
            prev = tensor_store[addr];
            case (mode_reg)
                MODE_OVERWRITE: res.data = dval;
                MODE_ADD:       res.data = prev + dval;
                default:        res.data = prev * dval;
            endcase
            tensor_store[addr] = res.data;
        end else begin
            res.data = tensor_store[addr];
        end
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        scatter_result_t   want;
        logic [31:0]       reg_value;
        if (!i_rst_n) begin
            axis_reg = AXIS_OUTER;
            mode_reg = MODE_OVERWRITE;
            dim_middle_reg = 1;
            dim_inner_reg = 1;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_AXIS:       axis_reg = i_pwdata[SEL_W-1:0];
                        REG_MODE:       mode_reg = i_pwdata[SEL_W-1:0];
                        REG_DIM_MIDDLE: dim_middle_reg = i_pwdata[DIM_W-1:0];
                        default:        dim_inner_reg = i_pwdata[DIM_W-1:0];
                    endcase
                end else begin
                    case (i_paddr[3:2])
                        REG_AXIS:       reg_value = 32'(axis_reg);
                        REG_MODE:       reg_value = 32'(mode_reg);
                        REG_DIM_MIDDLE: reg_value = 32'(dim_middle_reg);
                        default:        reg_value = 32'(dim_inner_reg);
                    endcase
                    if (i_prdata !== reg_value) begin
                        note_mismatch("register readback", reg_value, i_prdata);
                    end
                end
            end
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result beat", '0, i_read_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_data !== want.data) begin
                        note_mismatch("read_data", want.data, i_read_data);
                    end
                    if (i_range_error !== want.range_error) begin
                        note_mismatch("range_error", 32'(want.range_error), 32'(i_range_error));
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_beat(i_action, i_flat_address, i_data_value, i_scatter_index,
                             i_pos_outer, i_pos_middle, i_pos_inner);
            end
        end
        o_pending = expected_results.size();
    end
endmodule

### dv/scatter_elements_reduce_3d_test.sv
// top-level testbench for the scatter-elements reduce block: clock, reset, stimulus, verdict
module scatter_elements_reduce_3d_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sere_pkg::*;
    import sere_test_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int ITEM_BUDGET = 1350;
    localparam int PHASES      = 12;

    typedef enum logic [1:0] {POP_STEADY, POP_MOSTLY, POP_SPARSE, POP_PERIODIC} pop_style_t;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_push = 1'b0;
    logic                  o_full;
    logic [1:0]            i_action = '0;
    logic [11:0]           i_flat_address = '0;
    logic [31:0]           i_data_value = '0;
    logic [11:0]           i_scatter_index = '0;
    logic [11:0]           i_pos_outer = '0;
    logic [11:0]           i_pos_middle = '0;
    logic [11:0]           i_pos_inner = '0;
    logic                  o_empty;
    logic                  i_pop = 1'b0;
    logic signed [31:0]    o_read_data;
    logic                  o_range_error;

    int                    fail_count;
    int                    pending;
    int                    sent;
    int                    popped;
    pop_style_t            pop_style;
    logic [7:0]            pop_tick;

    bit                    written [STORE_DEPTH];
    int                    written_list[$];
    t_sel                  cur_axis = AXIS_OUTER;
    t_sel                  cur_mode = MODE_OVERWRITE;
    logic [DIM_W-1:0]      cur_dm = 1;
    logic [DIM_W-1:0]      cur_di = 1;

    scatter_elements_reduce_3d #(.STORE_DEPTH(STORE_DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_push(i_push), .o_full(o_full),
        .i_action(i_action), .i_flat_address(i_flat_address), .i_data_value(i_data_value),
        .i_scatter_index(i_scatter_index), .i_pos_outer(i_pos_outer),
        .i_pos_middle(i_pos_middle), .i_pos_inner(i_pos_inner),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_read_data(o_read_data), .o_range_error(o_range_error)
    );

    scatter_elements_reduce_3d_check #(.STORE_DEPTH(STORE_DEPTH)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .i_push(i_push), .i_full(o_full),
        .i_action(i_action), .i_flat_address(i_flat_address), .i_data_value(i_data_value),
        .i_scatter_index(i_scatter_index), .i_pos_outer(i_pos_outer),
        .i_pos_middle(i_pos_middle), .i_pos_inner(i_pos_inner),
        .i_empty(o_empty), .i_pop(i_pop),
        .i_read_data(o_read_data), .i_range_error(o_range_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("scatter_elements_reduce_3d test failed");
        $finish;
    end

    // result side: the stall style is picked anew each time pop_tick wraps to zero
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            pop_style <= POP_STEADY;
            pop_tick <= '0;
            popped = 0;
        end else begin
            if (i_pop && !o_empty) begin
                popped++;
            end
            pop_tick <= pop_tick + 1'b1;
            if (pop_tick == 0) begin
                pop_style <= pop_style_t'($urandom_range(0, 3));
            end
            case (pop_style)
                POP_STEADY:   i_pop <= 1'b1;
                POP_MOSTLY:   i_pop <= ($urandom_range(0, 3) != 0);
                POP_SPARSE:   i_pop <= ($urandom_range(0, 3) == 0);
                default:      i_pop <= (pop_tick[4:0] < 5);
            endcase
        end
    end

    task automatic mark_written(logic [11:0] a);
        if (!written[a]) begin
            written[a] = 1'b1;
            written_list.push_back(a);
        end
    endtask

    task automatic send_beat(
        t_sel act, logic [11:0] fa, logic [31:0] dval,
        logic [11:0] si, logic [11:0] po, logic [11:0] pm, logic [11:0] pi
    );
        logic [63:0] addr;
        i_push <= 1'b1;
        i_action <= act;
        i_flat_address <= fa;
        i_data_value <= dval;
        i_scatter_index <= si;
        i_pos_outer <= po;
        i_pos_middle <= pm;
        i_pos_inner <= pi;
        do @(posedge i_clk); while (o_full);
        sent++;
        if (act == ACT_LOAD) begin
            mark_written(fa);
        end else if (act == ACT_SCATTER) begin
            addr = tensor_offset(cur_axis, cur_dm, cur_di, si, po, pm, pi);
            if (addr < STORE_DEPTH) begin
                mark_written(addr[11:0]);
            end
        end
    endtask

    task automatic wait_idle();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (popped != sent) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, t_sel idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(t_sel axis, t_sel mode, logic [DIM_W-1:0] dm,
                              logic [DIM_W-1:0] di);
        wait_idle();
        apb_access(1'b1, REG_AXIS, 32'(axis));
        apb_access(1'b1, REG_MODE, 32'(mode));
        apb_access(1'b1, REG_DIM_MIDDLE, 32'(dm));
        apb_access(1'b1, REG_DIM_INNER, 32'(di));
        apb_access(1'b0, REG_AXIS, '0);
        apb_access(1'b0, REG_MODE, '0);
        apb_access(1'b0, REG_DIM_MIDDLE, '0);
        apb_access(1'b0, REG_DIM_INNER, '0);
        cur_axis = axis;
        cur_mode = mode;
        cur_dm = dm;
        cur_di = di;
    endtask

    task automatic random_beat();
        int          pick;
        int          span_o;
        int          span_m;
        int          span_i;
        longint      plane;
        t_sel        act;
        logic [11:0] fa;
        logic [11:0] si;
        logic [11:0] po;
        logic [11:0] pm;
        logic [11:0] pi;
        logic [31:0] dval;
        logic [63:0] addr;
        fa = 12'($urandom);
        si = 12'($urandom);
        po = 12'($urandom);
        pm = 12'($urandom);
        pi = 12'($urandom);
        dval = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            act = ACT_LOAD;
            if ($urandom_range(0, 1) == 0) begin
                fa = 12'($urandom_range(0, 255));
            end
        end else if (pick < 75) begin
            act = ACT_SCATTER;
            // mostly coordinates that land inside the store
            if ($urandom_range(0, 3) != 0) begin
                span_i = (cur_di == 0 || cur_di > 4096) ? 4095 : int'(cur_di) - 1;
                span_m = (cur_dm == 0 || cur_dm > 4096) ? 4095 : int'(cur_dm) - 1;
                plane = longint'(cur_dm) * longint'(cur_di);
                span_o = (plane == 0) ? 4095 : int'(4095 / plane);
                po = 12'($urandom_range(0, span_o));
                pm = 12'($urandom_range(0, span_m));
                pi = 12'($urandom_range(0, span_i));
                case (cur_axis)
                    AXIS_OUTER:  si = 12'($urandom_range(0, span_o));
                    AXIS_MIDDLE: si = 12'($urandom_range(0, span_m));
                    default:     si = 12'($urandom_range(0, span_i));
                endcase
            end
            addr = tensor_offset(cur_axis, cur_dm, cur_di, si, po, pm, pi);
            // never combine with an entry that holds nothing yet
            if (addr < STORE_DEPTH && !written[addr[11:0]] && cur_mode != MODE_OVERWRITE) begin
                act = ACT_LOAD;
                fa = addr[11:0];
            end
        end else begin
            act = (pick < 95) ? ACT_READ : ACT_READ_ALT;
            if (written_list.size() == 0) begin
                act = ACT_LOAD;
            end else begin
                fa = 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
            end
        end
        send_beat(act, fa, dval, si, po, pm, pi);
    endtask

    task automatic run_bursts(int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0) begin
                random_beat();
                burst--;
                count--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int per_phase;
        logic [DIM_W-1:0] dm_pick;
        logic [DIM_W-1:0] di_pick;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: outer axis, overwrite, unit dims
        send_beat(ACT_LOAD, 12'd0, 32'h7fff_ffff, '0, '0, '0, '0);
        send_beat(ACT_LOAD, 12'hfff, 32'h8000_0000, '0, '0, '0, '0);
        send_beat(ACT_LOAD, 12'd1, 32'hffff_ffff, '0, '0, '0, '0);
        send_beat(ACT_READ, 12'd0, '0, '0, '0, '0, '0);
        send_beat(ACT_READ, 12'hfff, '0, '0, '0, '0, '0);
        send_beat(ACT_READ_ALT, 12'd1, '0, '0, '0, '0, '0);
        send_beat(ACT_SCATTER, '0, 32'd5, 12'd2, '0, '0, '0);
        send_beat(ACT_SCATTER, '0, 32'd9, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_beat(ACT_SCATTER, '0, 32'h1234_5678, 12'd0, '0, 12'hfff, '0);
        send_beat(ACT_READ, 12'd2, '0, '0, '0, '0, '0);

        // add wraps past the top of the signed range
        set_config(AXIS_OUTER, MODE_ADD, 1, 1);
        send_beat(ACT_SCATTER, '0, 32'd1, '0, '0, '0, '0);
        send_beat(ACT_READ, 12'd0, '0, '0, '0, '0, '0);

        set_config(AXIS_INNER, MODE_MUL, 2, 3);
        send_beat(ACT_SCATTER, '0, 32'hffff_ffff, 12'd1, '0, '0, '0);
        send_beat(ACT_SCATTER, '0, 32'd2, 12'd0, 12'd682, 12'd1, '0);
        send_beat(ACT_SCATTER, '0, 32'd2, 12'd0, 12'd683, '0, '0);

        // folded selectors with zero dims
        set_config(AXIS_ALIAS_INNER, MODE_ALIAS_MUL, 0, 0);
        send_beat(ACT_SCATTER, '0, 32'd3, 12'd2, 12'hfff, 12'hfff, '0);

        set_config(AXIS_MIDDLE, MODE_OVERWRITE, 13'h1fff, 13'h1fff);
        send_beat(ACT_SCATTER, '0, 32'd7, 12'd0, '0, '0, 12'hfff);
        send_beat(ACT_SCATTER, '0, 32'd7, 12'd1, '0, '0, '0);

        per_phase = ITEM_BUDGET / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(AXIS_OUTER, MODE_OVERWRITE, 16, 16);
                1: set_config(AXIS_MIDDLE, MODE_MUL, 8, 4);
                2: set_config(AXIS_INNER, MODE_ADD, 64, 64);
                3: set_config(AXIS_ALIAS_INNER, MODE_ALIAS_MUL, 4096, 1);
                4: set_config(AXIS_OUTER, MODE_ADD, 0, 0);
                5: set_config(AXIS_MIDDLE, MODE_ADD, 13'h1fff, 13'h1fff);
                6: set_config(AXIS_INNER, MODE_MUL, 1, 4096);
                default: begin
                    dm_pick = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(1, 32))
                                                          : 13'($urandom_range(0, 8191));
                    di_pick = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(1, 32))
                                                          : 13'($urandom_range(0, 8191));
                    set_config(t_sel'($urandom_range(0, 3)), t_sel'($urandom_range(0, 3)),
                               dm_pick, di_pick);
                end
            endcase
            run_bursts(per_phase / 2);
            if (p % 4 == 1) begin
                wait_idle();
            end
            run_bursts(per_phase - per_phase / 2);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("scatter_elements_reduce_3d test passed");
        end else begin
            $display("scatter_elements_reduce_3d test failed");
        end
        $finish;
    end
endmodule

### sim.f
design/sere_pkg.sv
design/sere_fifo.sv
design/sere_front.sv
design/sere_back.sv
design/scatter_elements_reduce_3d.sv
dv/scatter_elements_reduce_3d_check.sv
dv/scatter_elements_reduce_3d_test.sv
